// File: rtl/core/cbor_hd_pkg.sv
package cbor_hd_pkg;

	localparam int unsigned ARG_W  = 64;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 4;

	localparam logic [4:0] INFO_MASK       = 5'h1F;
	localparam logic [4:0] INFO_DIRECT_MAX = 5'd23;
	localparam logic [4:0] INFO_ARG8       = 5'd24;
	localparam logic [4:0] INFO_ARG16      = 5'd25;
	localparam logic [4:0] INFO_ARG32      = 5'd26;
	localparam logic [4:0] INFO_ARG64      = 5'd27;

	localparam logic [2:0] MT_BSTR = 3'd2;
	localparam logic [2:0] MT_TSTR = 3'd3;

	localparam logic KIND_HEAD    = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic              kind;
		logic [2:0]        major_type;
		logic [ARG_W-1:0]  argument;
		logic [BYTE_W-1:0] payload_byte;
		logic              malformed;
		logic              last_payload;
	} result_t;

endpackage

// File: rtl/core/cbor_head_stream_decoder_unit.sv
// CBOR data item head decoder, one stream byte per input transfer.
// Input channel: in_valid/in_ready with in_byte, the next byte of the stream.
// Output channel: out_valid/out_ready with kind, major_type, argument,
// payload_byte, malformed and last_payload. A head result (kind 0) carries the
// major type and decoded argument; a payload result (kind 1) carries one byte
// of a byte or text string, with last_payload on the final byte.
// Initial bytes with info 0..23 or 28..31 and every payload byte give one
// result; argument bytes of a 1/2/4/8 byte argument give none until the last.
// Each result is registered, in the output register or, while an earlier
// result waits, in the skid register. Throughput: one byte per cycle while
// in_ready is high, set by the single register stage after the decode logic.
// A two-entry output buffer (output register plus skid register) lets the
// block take one more byte while a result waits; in_ready drops only while
// both entries are full, and it comes from a register.
// Reset (arst_n low, asynchronous): the decoder expects an initial byte and
// the output buffer is empty.
module cbor_head_stream_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cbor_hd_pkg::BYTE_W-1:0]  in_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [2:0]                      major_type,
	output logic [cbor_hd_pkg::ARG_W-1:0]   argument,
	output logic [cbor_hd_pkg::BYTE_W-1:0]  payload_byte,
	output logic                            malformed,
	output logic                            last_payload
);
	import cbor_hd_pkg::*;

	phase_t             phase_q, phase_nxt;
	logic [2:0]         major_q, major_nxt;
	logic [CNT_W-1:0]   cnt_q, cnt_nxt;
	logic [ARG_W-1:0]   acc_q, acc_nxt;
	logic [ARG_W-1:0]   rem_q, rem_nxt;

	result_t            res;
	logic               res_valid;
	logic               head_done;
	logic               head_malf;
	logic [ARG_W-1:0]   head_arg;
	logic [4:0]         info;
	logic               to_payload;

	result_t            out_q, skid_q;
	logic               out_valid_q, skid_valid_q;
	logic               accept, push, pop;

	assign accept = in_valid && in_ready;
	assign info   = in_byte[4:0] & INFO_MASK;

	// Datapath and result decode
	always_comb begin
		res          = '0;
		res_valid    = 1'b0;
		head_done    = 1'b0;
		head_malf    = 1'b0;
		head_arg     = '0;
		major_nxt    = major_q;
		cnt_nxt      = cnt_q;
		acc_nxt      = acc_q;
		rem_nxt      = rem_q;
		case (phase_q)
			PH_COLLECT: begin
				acc_nxt  = {acc_q[ARG_W-BYTE_W-1:0], in_byte};
				cnt_nxt  = cnt_q - CNT_W'(1);
				head_arg = acc_nxt;
				if (cnt_nxt == '0) begin
					head_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res_valid          = 1'b1;
				res.kind           = KIND_PAYLOAD;
				res.major_type     = major_q;
				res.payload_byte   = in_byte;
				res.last_payload   = (rem_q[ARG_W-1:1] == '0);
				rem_nxt            = res.last_payload ? '0 : rem_q - ARG_W'(1);
			end
			default: begin
				major_nxt = in_byte[7:5];
				acc_nxt   = '0;
				case (info) inside
					[5'd0:INFO_DIRECT_MAX]: begin
						head_done = 1'b1;
						head_arg  = ARG_W'(info);
					end
					INFO_ARG8:  cnt_nxt = CNT_W'(1);
					INFO_ARG16: cnt_nxt = CNT_W'(2);
					INFO_ARG32: cnt_nxt = CNT_W'(4);
					INFO_ARG64: cnt_nxt = CNT_W'(8);
					default: begin
						head_done = 1'b1;
						head_malf = 1'b1;
					end
				endcase
			end
		endcase
		to_payload = head_done && !head_malf && head_arg != '0
			&& (major_nxt == MT_BSTR || major_nxt == MT_TSTR);
		if (head_done) begin
			res_valid      = 1'b1;
			res.kind       = KIND_HEAD;
			res.major_type = major_nxt;
			res.argument   = head_arg;
			res.malformed  = head_malf;
			rem_nxt        = to_payload ? head_arg : '0;
		end
	end

	// Next phase
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_COLLECT: begin
				if (cnt_nxt == '0) begin
					phase_nxt = to_payload ? PH_PAYLOAD : PH_IDLE;
				end
			end
			PH_PAYLOAD: begin
				if (res.last_payload) begin
					phase_nxt = PH_IDLE;
				end
			end
			default: begin
				if (head_done) begin
					phase_nxt = to_payload ? PH_PAYLOAD : PH_IDLE;
				end else begin
					phase_nxt = PH_COLLECT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			major_q <= major_nxt;
			acc_q   <= acc_nxt;
			rem_q   <= rem_nxt;
		end
	end

	// Output register with skid entry
	assign push = accept && res_valid;
	assign pop  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign in_ready     = !skid_valid_q;
	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign major_type   = out_q.major_type;
	assign argument     = out_q.argument;
	assign payload_byte = out_q.payload_byte;
	assign malformed    = out_q.malformed;
	assign last_payload = out_q.last_payload;

`ifndef NO_ASSERTIONS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_collect_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COLLECT |-> cnt_q != '0)
		else $error("collecting argument bytes with zero count");

	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("passing payload with nothing remaining");

	a_head_no_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_HEAD |->
			out_q.payload_byte == '0 && !out_q.last_payload)
		else $error("head result carries payload fields");
`endif

endmodule
